[src/gclfu_pkg.sv]
`default_nettype none

package gclfu_pkg;

    // Table sizing
    localparam int CAPACITY = 256;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int CODE_W  = 21;
    localparam int USE_W   = 16;
    localparam int CELL_W  = 8;
    localparam int COL_W   = 4;
    localparam int ROW_W   = 5;
    localparam int DIM_W   = 5;
    localparam int PROD_W  = 2 * DIM_W - 1;
    localparam int CMP_W   = CNT_W + PROD_W;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_CELLS_PER_ROW = 1'b0;
    localparam logic REG_CELL_ROWS     = 1'b1;

    // Item commands
    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_BUMP    = 1'b1;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
    } t_dp_status;

    typedef struct packed {
        logic [CODE_W-1:0] key;
        logic [USE_W-1:0]  use_count;
        logic [CELL_W-1:0] atlas_pos;
    } t_entry;

    typedef struct packed {
        logic              hit;
        logic              allocated;
        logic              evicted;
        logic [CODE_W-1:0] evicted_code;
        logic [COL_W-1:0]  cell_column;
        logic [COL_W-1:0]  cell_row;
    } t_result;

    // Force a dimension register into 1..16
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(16)) begin
            r = DIM_W'(16);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/gclfu_ctrl.sv]
`default_nettype none

module gclfu_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output gclfu_pkg::t_dp_cmd    o_cmd,
    input  gclfu_pkg::t_dp_status i_status
);
    import gclfu_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;
    logic       accept;

    assign out_free = !r_out_valid || i_out_ready;
    assign accept   = i_in_valid && (r_state == ST_IDLE);

    assign o_cmd.load   = accept;
    assign o_cmd.scan   = (r_state == ST_SCAN);
    assign o_cmd.commit = (r_state == ST_DECIDE) && out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.scan_done) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

[src/gclfu_dp.sv]
`default_nettype none

module gclfu_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  gclfu_pkg::t_dp_cmd              i_cmd,
    output gclfu_pkg::t_dp_status           o_status,
    input  logic                           i_command,
    input  logic [gclfu_pkg::CODE_W-1:0]   i_glyph_code,
    input  logic [gclfu_pkg::DIM_W-1:0]    i_cells_per_row,
    input  logic [gclfu_pkg::DIM_W-1:0]    i_cell_rows,
    output gclfu_pkg::t_result              o_result
);
    import gclfu_pkg::*;

    // Entry store: key, use count and cell per table slot
    t_entry             mem [CAPACITY];
    t_entry             r_q;

    logic [CODE_W-1:0]  r_code;
    logic               r_op;
    logic [CNT_W-1:0]   r_addr;
    logic               r_pend;
    logic [IDX_W-1:0]   r_pidx;
    logic               r_found;
    logic [IDX_W-1:0]   r_hit_idx;
    t_entry             r_hit;
    logic               r_have_best;
    logic [IDX_W-1:0]   r_best_idx;
    t_entry             r_best;
    logic [CNT_W-1:0]   r_count;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    t_result            r_res;

    logic [IDX_W-1:0]   rd_addr;
    logic               issue;
    logic               match;
    logic               better;
    logic [DIM_W-1:0]   cpr_c;
    logic [DIM_W-1:0]   rows_c;
    logic [PROD_W-1:0]  prod;
    logic               alloc_ok;
    logic               col_wrap;
    logic [USE_W-1:0]   bumped;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;
    t_result            res;
    logic               do_alloc;

    assign rd_addr = r_addr[IDX_W-1:0];
    assign issue   = i_cmd.scan && !r_found && (r_addr < r_count);
    assign match   = r_pend && !r_found && (r_q.key == r_code);
    assign better  = r_pend && !r_found &&
                     (!r_have_best || (r_q.use_count < r_best.use_count));

    assign o_status.scan_done = !r_pend && (r_found || (r_addr >= r_count));

    assign cpr_c    = clamp_dim(i_cells_per_row);
    assign rows_c   = clamp_dim(i_cell_rows);
    assign prod     = PROD_W'(cpr_c) * PROD_W'(rows_c);
    assign alloc_ok = (CMP_W'(r_count) < CMP_W'(prod)) && (r_count < CNT_W'(CAPACITY));
    assign col_wrap = (DIM_W'(r_col) + DIM_W'(1)) >= cpr_c;
    assign bumped   = (r_hit.use_count == '1) ? r_hit.use_count
                                              : r_hit.use_count + USE_W'(1);

    // Decide the outcome once the scan has finished
    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = '0;
        res      = '0;
        do_alloc = 1'b0;
        if (r_found) begin
            res.hit         = 1'b1;
            res.cell_column = r_hit.atlas_pos[COL_W-1:0];
            res.cell_row    = r_hit.atlas_pos[CELL_W-1:COL_W];
            if (r_op == CMD_BUMP) begin
                wr_en   = 1'b1;
                wr_addr = r_hit_idx;
                wr_data = '{key: r_hit.key, use_count: bumped, atlas_pos: r_hit.atlas_pos};
            end
        end else if (r_op == CMD_REQUEST) begin
            if (alloc_ok) begin
                do_alloc        = 1'b1;
                wr_en           = 1'b1;
                wr_addr         = r_count[IDX_W-1:0];
                wr_data         = '{key: r_code, use_count: USE_W'(1),
                                    atlas_pos: {r_row[COL_W-1:0], r_col}};
                res.allocated   = 1'b1;
                res.cell_column = r_col;
                res.cell_row    = r_row[COL_W-1:0];
            end else if (r_have_best) begin
                wr_en            = 1'b1;
                wr_addr          = r_best_idx;
                wr_data          = '{key: r_code, use_count: USE_W'(1),
                                     atlas_pos: r_best.atlas_pos};
                res.allocated    = 1'b1;
                res.evicted      = 1'b1;
                res.evicted_code = r_best.key;
                res.cell_column  = r_best.atlas_pos[COL_W-1:0];
                res.cell_row     = r_best.atlas_pos[CELL_W-1:COL_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_q <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_have_best <= 1'b0;
        end else if (i_cmd.load) begin
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_have_best <= 1'b0;
        end else if (i_cmd.scan) begin
            if (issue) r_addr <= r_addr + CNT_W'(1);
            r_pend <= issue;
            if (match)  r_found     <= 1'b1;
            if (better) r_have_best <= 1'b1;
        end else if (i_cmd.commit && do_alloc) begin
            r_count <= r_count + CNT_W'(1);
            if (col_wrap) begin
                r_col <= '0;
                r_row <= r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_code <= i_glyph_code;
            r_op   <= i_command;
        end
        if (i_cmd.scan) begin
            r_pidx <= rd_addr;
            if (match) begin
                r_hit_idx <= r_pidx;
                r_hit     <= r_q;
            end
            if (better) begin
                r_best_idx <= r_pidx;
                r_best     <= r_q;
            end
        end
        if (i_cmd.commit) begin
            r_res <= res;
        end
    end

    assign o_result = r_res;

endmodule

`default_nettype wire

[src/glyph_cache_lfu_replacement.sv]
// Channel   | Signals                                          | Moves
// ----------+--------------------------------------------------+------------------------
// in        | i_in_valid, o_in_ready, i_command, i_glyph_code  | one item: request/bump
// out       | o_out_valid, i_out_ready, o_hit .. o_cell_row    | one result per item
// config    | psel, penable, pwrite, paddr, pwdata, prdata     | cells_per_row, cell_rows
//
// The lookup and least-used search walk the entry memory through its single
// read port, one entry a cycle, stopping early on a hit.
// Reset clears control, the fill count and the placement cursor and sets both
// configuration registers to 16; the entry memory is tracked by the fill
// count, so there is no clearing pass. A stalled result holds in the
// output register while the next item is already accepted and scanned.
`default_nettype none

module glyph_cache_lfu_replacement (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // item input
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_command,
    input  logic [gclfu_pkg::CODE_W-1:0]       i_glyph_code,
    // result output
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_hit,
    output logic                               o_allocated,
    output logic                               o_evicted,
    output logic [gclfu_pkg::CODE_W-1:0]       o_evicted_code,
    output logic [gclfu_pkg::COL_W-1:0]        o_cell_column,
    output logic [gclfu_pkg::COL_W-1:0]        o_cell_row,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gclfu_pkg::PADDR_W-1:0]      paddr,
    input  logic [gclfu_pkg::PDATA_W-1:0]      pwdata,
    output logic [gclfu_pkg::PDATA_W-1:0]      prdata,
    output logic                               pready
);
    import gclfu_pkg::*;

    logic [DIM_W-1:0] r_cells_per_row;
    logic [DIM_W-1:0] r_cell_rows;
    logic             cfg_wr;
    logic             reg_sel;
    t_dp_cmd          dp_cmd;
    t_dp_status       dp_status;
    t_result          result;

    // Register file: index is the word address
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_per_row <= DIM_W'(16);
            r_cell_rows     <= DIM_W'(16);
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_CELLS_PER_ROW: r_cells_per_row <= pwdata[DIM_W-1:0];
                REG_CELL_ROWS:     r_cell_rows     <= pwdata[DIM_W-1:0];
                default:           r_cell_rows     <= r_cell_rows;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_CELLS_PER_ROW: prdata = PDATA_W'(r_cells_per_row);
            REG_CELL_ROWS:     prdata = PDATA_W'(r_cell_rows);
            default:           prdata = '0;
        endcase
    end

    // Sequencer: accept, scan, decide, hand off to the output register
    gclfu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    // Entry memory, scan pipeline, placement cursor and result register
    gclfu_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_command       (i_command),
        .i_glyph_code    (i_glyph_code),
        .i_cells_per_row (r_cells_per_row),
        .i_cell_rows     (r_cell_rows),
        .o_result        (result)
    );

    assign o_hit          = result.hit;
    assign o_allocated    = result.allocated;
    assign o_evicted      = result.evicted;
    assign o_evicted_code = result.evicted_code;
    assign o_cell_column  = result.cell_column;
    assign o_cell_row     = result.cell_row;

endmodule

`default_nettype wire

[src/gclfu_checker.sv]
`default_nettype none

module gclfu_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         o_in_ready,
    input  logic                         o_out_valid,
    input  logic                         i_out_ready,
    input  logic                         o_hit,
    input  logic                         o_allocated,
    input  logic                         o_evicted,
    input  logic [gclfu_pkg::CODE_W-1:0] o_evicted_code
);
    import gclfu_pkg::*;

    // hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("accepted a second item during a scan");

    a_hit_not_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_allocated))
        else $error("hit and allocation in one result");

    a_evict_is_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_evicted |-> o_allocated)
        else $error("eviction without allocation");

    a_evict_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_evicted |-> (o_evicted_code == '0))
        else $error("evicted code set without eviction");

endmodule

bind glyph_cache_lfu_replacement gclfu_checker u_gclfu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_hit          (o_hit),
    .o_allocated    (o_allocated),
    .o_evicted      (o_evicted),
    .o_evicted_code (o_evicted_code)
);

`default_nettype wire
